// ===== src/alle_pkg.sv =====
`default_nettype none

package alle_pkg;

  localparam int LIST_SLOTS_DEF = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
    logic        [3:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] removed_value;
    logic        [3:0]  slot_used;
    logic               empty_res;
  } out_item_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

`default_nettype wire

// ===== src/array_linked_list_engine.sv =====
`default_nettype none

// channel  | ports                          | moves
// ---------+--------------------------------+------------------------------
// input    | in_valid, in_ready, in_item    | mode, value, slot
// result   | out_valid, out_ready, out_item | ok, removed_value, slot_used,
//          |                                | empty_res
//
// one item at a time; a walk follows at most LIST_SLOTS-1 links, one per cycle
// through the read port of the link memory. an insert into an empty list and a
// remove of the head need no walk; an item refused at the start goes straight to
// its result. untouched link entries answer i+1 through a fill count, so there
// is no clearing pass.
// a waiting result sits in the output register; the sequencer holds its own
// finished result until that register frees, then takes the next item.

module array_linked_list_engine #(
  parameter int LIST_SLOTS = alle_pkg::LIST_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire alle_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output alle_pkg::out_item_t      out_item
);

  localparam int AW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
  localparam int LW = $clog2(LIST_SLOTS + 1);

  logic                lk_re, lk_we;
  logic [AW-1:0]       lk_raddr, lk_waddr;
  logic [LW-1:0]       lk_rdata, lk_wdata;
  logic                vl_re, vl_we;
  logic [AW-1:0]       vl_raddr, vl_waddr;
  logic signed [31:0]  vl_rdata, vl_wdata;
  alle_pkg::res_t      res;
  logic                res_ready;
  logic                out_valid_r;
  alle_pkg::out_item_t out_item_r;

  alle_ctrl #(.N(LIST_SLOTS), .AW(AW), .LW(LW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .res      (res),
    .res_ready(res_ready),
    .lk_re    (lk_re),
    .lk_raddr (lk_raddr),
    .lk_rdata (lk_rdata),
    .lk_we    (lk_we),
    .lk_waddr (lk_waddr),
    .lk_wdata (lk_wdata),
    .vl_re    (vl_re),
    .vl_raddr (vl_raddr),
    .vl_rdata (vl_rdata),
    .vl_we    (vl_we),
    .vl_waddr (vl_waddr),
    .vl_wdata (vl_wdata)
  );

  alle_link_mem #(.N(LIST_SLOTS), .AW(AW), .LW(LW)) u_link_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .re   (lk_re),
    .raddr(lk_raddr),
    .rdata(lk_rdata),
    .we   (lk_we),
    .waddr(lk_waddr),
    .wdata(lk_wdata)
  );

  alle_val_mem #(.N(LIST_SLOTS), .AW(AW)) u_val_mem (
    .clk  (clk),
    .re   (vl_re),
    .raddr(vl_raddr),
    .rdata(vl_rdata),
    .we   (vl_we),
    .waddr(vl_waddr),
    .wdata(vl_wdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
    if (res_ready && res.valid) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== src/alle_link_mem.sv =====
`default_nettype none

module alle_link_mem #(
  parameter int N  = alle_pkg::LIST_SLOTS_DEF,
  parameter int AW = 4,
  parameter int LW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [LW-1:0] rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [LW-1:0] wdata
);

  logic [LW-1:0] mem [N];
  logic [LW-1:0] raw_r;
  logic [LW-1:0] impl_r;
  logic          untouched_r;
  // entries at or above fill_r were never written and still hold their reset link i+1
  logic [LW-1:0] fill_r;
  logic [LW-1:0] fill_nxt;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      raw_r       <= mem[raddr];
      impl_r      <= LW'(raddr) + LW'(1);
      untouched_r <= (LW'(raddr) >= fill_r);
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (we && (LW'(waddr) == fill_r)) begin
      fill_nxt = fill_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign rdata = untouched_r ? impl_r : raw_r;

endmodule

`default_nettype wire

// ===== src/alle_val_mem.sv =====
`default_nettype none

module alle_val_mem #(
  parameter int N  = alle_pkg::LIST_SLOTS_DEF,
  parameter int AW = 4
) (
  input  wire logic               clk,
  input  wire logic               re,
  input  wire logic        [AW-1:0] raddr,
  output logic signed [31:0]      rdata,
  input  wire logic               we,
  input  wire logic        [AW-1:0] waddr,
  input  wire logic signed [31:0] wdata
);

  logic signed [31:0] mem [N];
  logic signed [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/alle_ctrl.sv =====
`default_nettype none

module alle_ctrl #(
  parameter int N  = alle_pkg::LIST_SLOTS_DEF,
  parameter int AW = 4,
  parameter int LW = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire alle_pkg::in_item_t in_item,
  output alle_pkg::res_t          res,
  input  wire logic               res_ready,
  output logic                    lk_re,
  output logic        [AW-1:0]    lk_raddr,
  input  wire logic   [LW-1:0]    lk_rdata,
  output logic                    lk_we,
  output logic        [AW-1:0]    lk_waddr,
  output logic        [LW-1:0]    lk_wdata,
  output logic                    vl_re,
  output logic        [AW-1:0]    vl_raddr,
  input  wire logic signed [31:0] vl_rdata,
  output logic                    vl_we,
  output logic        [AW-1:0]    vl_waddr,
  output logic signed [31:0]      vl_wdata
);

  localparam logic [LW-1:0] NIL = LW'(N);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_FREE,
    S_INS_WALK,
    S_RM_HEAD,
    S_RM_WALK,
    S_RM_SPLICE,
    S_RM_FREE,
    S_RESULT
  } state_t;

  state_t               state_r, state_nxt;
  logic      [LW-1:0]   list_head_r, list_head_nxt;
  logic      [LW-1:0]   free_head_r, free_head_nxt;
  logic      [LW-1:0]   fresh_r, fresh_nxt;
  logic      [LW-1:0]   tgt_r, tgt_nxt;
  logic      [LW-1:0]   cur_r, cur_nxt;
  logic      [LW-1:0]   steps_r, steps_nxt;
  alle_pkg::out_item_t  res_r, res_nxt;
  logic                 tgt_in;

  function automatic logic slot_ok(input logic [LW-1:0] x);
    return x < NIL;
  endfunction

  assign tgt_in = (32'(in_item.slot) < 32'(N));

  always_comb begin
    state_nxt     = state_r;
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    tgt_nxt       = tgt_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    res_nxt       = res_r;
    lk_re         = 1'b0;
    lk_raddr      = AW'(cur_r);
    lk_we         = 1'b0;
    lk_waddr      = AW'(cur_r);
    lk_wdata      = NIL;
    vl_re         = 1'b0;
    vl_raddr      = AW'(in_item.slot);
    vl_we         = 1'b0;
    vl_waddr      = AW'(free_head_r);
    vl_wdata      = in_item.value;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '{ok: 1'b0, removed_value: 32'sd0, slot_used: 4'd0,
                      empty_res: !slot_ok(list_head_r)};
          state_nxt = S_RESULT;
          if (in_item.mode == alle_pkg::MODE_INSERT) begin
            if (slot_ok(free_head_r)) begin
              vl_we     = 1'b1;
              lk_re     = 1'b1;
              lk_raddr  = AW'(free_head_r);
              fresh_nxt = free_head_r;
              state_nxt = S_INS_FREE;
            end
          end else begin
            tgt_nxt = LW'(in_item.slot);
            if (slot_ok(list_head_r) && tgt_in) begin
              vl_re = 1'b1;
              lk_re = 1'b1;
              if (list_head_r == LW'(in_item.slot)) begin
                lk_raddr  = AW'(in_item.slot);
                state_nxt = S_RM_HEAD;
              end else begin
                lk_raddr  = AW'(list_head_r);
                cur_nxt   = list_head_r;
                steps_nxt = '0;
                state_nxt = S_RM_WALK;
              end
            end
          end
        end
      end

      S_INS_FREE: begin
        free_head_nxt = lk_rdata;
        lk_we         = 1'b1;
        lk_waddr      = AW'(fresh_r);
        lk_wdata      = NIL;
        if (!slot_ok(list_head_r)) begin
          list_head_nxt = fresh_r;
          res_nxt = '{ok: 1'b1, removed_value: 32'sd0, slot_used: 4'(fresh_r),
                      empty_res: 1'b0};
          state_nxt = S_RESULT;
        end else begin
          lk_re     = 1'b1;
          lk_raddr  = AW'(list_head_r);
          cur_nxt   = list_head_r;
          steps_nxt = '0;
          state_nxt = S_INS_WALK;
        end
      end

      S_INS_WALK: begin
        // tail found, or walk bound hit: hook the fresh node on here
        if (!slot_ok(lk_rdata) || (steps_r == NIL)) begin
          lk_we    = 1'b1;
          lk_waddr = AW'(cur_r);
          lk_wdata = fresh_r;
          res_nxt = '{ok: 1'b1, removed_value: 32'sd0, slot_used: 4'(fresh_r),
                      empty_res: 1'b0};
          state_nxt = S_RESULT;
        end else begin
          cur_nxt   = lk_rdata;
          lk_re     = 1'b1;
          lk_raddr  = AW'(lk_rdata);
          steps_nxt = steps_r + LW'(1);
        end
      end

      S_RM_HEAD: begin
        list_head_nxt = lk_rdata;
        free_head_nxt = tgt_r;
        lk_we         = 1'b1;
        lk_waddr      = AW'(tgt_r);
        lk_wdata      = free_head_r;
        res_nxt = '{ok: 1'b1, removed_value: vl_rdata, slot_used: 4'(tgt_r),
                    empty_res: !slot_ok(lk_rdata)};
        state_nxt = S_RESULT;
      end

      S_RM_WALK: begin
        if (lk_rdata == tgt_r) begin
          lk_re     = 1'b1;
          lk_raddr  = AW'(tgt_r);
          state_nxt = S_RM_SPLICE;
        end else if (!slot_ok(lk_rdata) || (steps_r == NIL)) begin
          res_nxt = '{ok: 1'b0, removed_value: 32'sd0, slot_used: 4'd0,
                      empty_res: !slot_ok(list_head_r)};
          state_nxt = S_RESULT;
        end else begin
          cur_nxt   = lk_rdata;
          lk_re     = 1'b1;
          lk_raddr  = AW'(lk_rdata);
          steps_nxt = steps_r + LW'(1);
        end
      end

      S_RM_SPLICE: begin
        // predecessor skips over the target
        lk_we     = 1'b1;
        lk_waddr  = AW'(cur_r);
        lk_wdata  = lk_rdata;
        state_nxt = S_RM_FREE;
      end

      S_RM_FREE: begin
        free_head_nxt = tgt_r;
        lk_we         = 1'b1;
        lk_waddr      = AW'(tgt_r);
        lk_wdata      = free_head_r;
        res_nxt = '{ok: 1'b1, removed_value: vl_rdata, slot_used: 4'(tgt_r),
                    empty_res: !slot_ok(list_head_r)};
        state_nxt = S_RESULT;
      end

      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= NIL;
      free_head_r <= '0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
    end
    fresh_r <= fresh_nxt;
    tgt_r   <= tgt_nxt;
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign res.valid  = (state_r == S_RESULT);
  assign res.item   = res_r;

endmodule

`default_nettype wire

// ===== src/alle_checker.sv =====
`default_nettype none

module alle_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire alle_pkg::out_item_t out_item
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one item in flight: no second accept right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // a failed operation reports zero value and slot
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.ok |-> (out_item.removed_value == 32'sd0) &&
                                  (out_item.slot_used == 4'd0))
    else $error("failed operation with nonzero fields");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind array_linked_list_engine alle_checker u_alle_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

`default_nettype wire
